[rtl/core/weighted_vertex_sampler_defines.svh]
// assertion macros for the weighted vertex sampler
// expects clk_i and rst_ni in the module that expands them
`ifndef WEIGHTED_VERTEX_SAMPLER_DEFINES_SVH
`define WEIGHTED_VERTEX_SAMPLER_DEFINES_SVH

// concurrent check on the module clock, off while in reset
`define WVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// antecedent one cycle, consequent the next
`define WVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wvs_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the weighted vertex sampler
// no dependencies
package wvs_pkg;

  localparam int unsigned NUM_VERTICES_DEF = 1024;
  localparam int unsigned IDX_OUT_W = 10;
  localparam int unsigned CNT_REG_W = 11;
  localparam int unsigned CRD_W = 32;
  localparam int unsigned TOT_W = 48;
  localparam int unsigned WGT_W = 32;
  localparam int unsigned ROOT_W = 34;
  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned DVS_W = ROOT_W + 1;
  localparam int unsigned MUL_W = CRD_W + 1;
  localparam logic [WGT_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_RESET  = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_READY   = 2'd1,
    ST_ZERO_RADIUS = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic                 slot_ok;
    logic [IDX_OUT_W-1:0] slot;
    logic [CRD_W-1:0]     x;
    logic [CRD_W-1:0]     y;
    logic [CRD_W-1:0]     z;
    logic [CRD_W-1:0]     gmag;
    logic                 gain_neg;
    logic [CRD_W-1:0]     radius;
    logic                 radius_zero;
    logic [CRD_W-1:0]     draw;
  } item_t;

  typedef struct packed {
    status_e              status;
    logic [IDX_OUT_W-1:0] index;
    logic [CRD_W-1:0]     x;
    logic [CRD_W-1:0]     y;
    logic [CRD_W-1:0]     z;
    logic [TOT_W-1:0]     total;
  } result_t;

endpackage

[rtl/core/weighted_vertex_sampler.sv]
`timescale 1ns / 1ps
// weighted vertex sampler top level: register port, front queue and engine
// depends on wvs_pkg, wvs_front, wvs_engine
//
//  port        direction  handshake            payload
//  config      in         psel/penable/pwrite  paddr, pwdata, prdata
//  request     in         in_valid_i/in_stall_o command_i .. draw_i
//  result      out        out_valid_o/out_stall_i status_o .. weight_total_o
//
// load and refused requests: answered straight from the idle state
// reset weights: one memory row per cycle over all NUM_VERTICES rows
// update: a 34-step root and a 32-step divide per vertex, then a prefix pass
//   over the n vertices in use
// sample: a binary search over the prefix sums, one prefix-sum memory read per step
// requests queue two deep while a result waits under out_stall_i
module weighted_vertex_sampler
  import wvs_pkg::*;
#(
  parameter int unsigned NUM_VERTICES = NUM_VERTICES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [IDX_OUT_W-1:0] vertex_index_i,
  input  logic [CRD_W-1:0]     coord_x_i,
  input  logic [CRD_W-1:0]     coord_y_i,
  input  logic [CRD_W-1:0]     coord_z_i,
  input  logic [CRD_W-1:0]     gain_i,
  input  logic [CRD_W-1:0]     radius_i,
  input  logic [CRD_W-1:0]     draw_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [IDX_OUT_W-1:0] chosen_index_o,
  output logic [CRD_W-1:0]     chosen_x_o,
  output logic [CRD_W-1:0]     chosen_y_o,
  output logic [CRD_W-1:0]     chosen_z_o,
  output logic [TOT_W-1:0]     weight_total_o
);

  localparam int unsigned CNT_W = $clog2(NUM_VERTICES + 1);

  logic [CNT_REG_W-1:0] vertex_count_q;
  logic                 cfg_wr;
  logic [CNT_W-1:0]     n_use;
  logic                 q_valid, q_pop;
  item_t                q_item;
  result_t              res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? '0 : 32'(vertex_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= CNT_REG_W'(1);
    end else if (cfg_wr) begin
      vertex_count_q <= pwdata[CNT_REG_W-1:0];
    end
  end

  always_comb begin
    if (vertex_count_q == '0) begin
      n_use = CNT_W'(1);
    end else if (32'(vertex_count_q) > NUM_VERTICES) begin
      n_use = CNT_W'(NUM_VERTICES);
    end else begin
      n_use = CNT_W'(vertex_count_q);
    end
  end

  wvs_front #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .vertex_index_i (vertex_index_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .coord_z_i      (coord_z_i),
    .gain_i         (gain_i),
    .radius_i       (radius_i),
    .draw_i         (draw_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  wvs_engine #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_clr_i   (cfg_wr),
    .n_i         (n_use),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_valid_o (out_valid_o),
    .res_o       (res),
    .out_stall_i (out_stall_i)
  );

  assign status_o       = res.status;
  assign chosen_index_o = res.index;
  assign chosen_x_o     = res.x;
  assign chosen_y_o     = res.y;
  assign chosen_z_o     = res.z;
  assign weight_total_o = res.total;

endmodule

[rtl/core/wvs_front.sv]
`timescale 1ns / 1ps
// front end: takes requests, classifies them and queues them for the engine
// depends on wvs_pkg
module wvs_front
  import wvs_pkg::*;
#(
  parameter int unsigned NUM_VERTICES = NUM_VERTICES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [IDX_OUT_W-1:0] vertex_index_i,
  input  logic [CRD_W-1:0]     coord_x_i,
  input  logic [CRD_W-1:0]     coord_y_i,
  input  logic [CRD_W-1:0]     coord_z_i,
  input  logic [CRD_W-1:0]     gain_i,
  input  logic [CRD_W-1:0]     radius_i,
  input  logic [CRD_W-1:0]     draw_i,
  output logic                 q_valid_o,
  output item_t                q_item_o,
  input  logic                 q_pop_i
);

  item_t       slots_q [2];
  item_t       item_in;
  logic [1:0]  count_q, count_d;
  logic        wr_ptr_q, rd_ptr_q;
  logic        push;

  always_comb begin
    item_in.cmd         = cmd_e'(command_i);
    item_in.slot_ok     = (32'(vertex_index_i) < NUM_VERTICES);
    item_in.slot        = vertex_index_i;
    item_in.x           = coord_x_i;
    item_in.y           = coord_y_i;
    item_in.z           = coord_z_i;
    item_in.gmag        = gain_i[CRD_W-1] ? (~gain_i + 32'd1) : gain_i;
    item_in.gain_neg    = gain_i[CRD_W-1];
    item_in.radius      = radius_i;
    item_in.radius_zero = (radius_i == '0);
    item_in.draw        = draw_i;
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = slots_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !q_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

[rtl/core/wvs_isqrt.sv]
`timescale 1ns / 1ps
// bit-serial integer square root, one result bit per cycle
// depends on wvs_pkg
module wvs_isqrt
  import wvs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic                busy_q, done_q;
  logic [5:0]          cnt_q;
  logic [RAD_W-1:0]    rad_q;
  logic [ROOT_W+1:0]   rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [ROOT_W+3:0]   rem_sh;
  logic [ROOT_W+3:0]   trial;
  logic                fits;

  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'(ROOT_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (fits) begin
        rem_q  <= (ROOT_W+2)'(rem_sh - trial);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= (ROOT_W+2)'(rem_sh);
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[rtl/core/wvs_div.sv]
`timescale 1ns / 1ps
// restoring divider, 32 quotient bits, one bit per cycle
// quotient must fit 32 bits; depends on wvs_pkg
module wvs_div
  import wvs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2*CRD_W-1:0]   dividend_i,
  input  logic [DVS_W-1:0]     divisor_i,
  output logic                 done_o,
  output logic [CRD_W-1:0]     quot_o
);

  logic               busy_q, done_q;
  logic [4:0]         cnt_q;
  logic [DVS_W-1:0]   rem_q, dvs_q;
  logic [CRD_W-1:0]   low_q, quot_q;
  logic [DVS_W:0]     rem_sh;
  logic               fits;

  assign rem_sh = {rem_q, low_q[CRD_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'(CRD_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(CRD_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= DVS_W'(dividend_i[2*CRD_W-1:CRD_W]);
      low_q  <= dividend_i[CRD_W-1:0];
      dvs_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      low_q <= low_q << 1;
      if (fits) begin
        rem_q  <= DVS_W'(rem_sh - {1'b0, dvs_q});
        quot_q <= {quot_q[CRD_W-2:0], 1'b1};
      end else begin
        rem_q  <= DVS_W'(rem_sh);
        quot_q <= {quot_q[CRD_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[rtl/core/wvs_engine.sv]
`timescale 1ns / 1ps
// back end: vertex, weight and prefix-sum memories and the command sequencer
// depends on wvs_pkg, wvs_isqrt, wvs_div and the assertion macros
`include "weighted_vertex_sampler_defines.svh"
module wvs_engine
  import wvs_pkg::*;
#(
  parameter int unsigned NUM_VERTICES = NUM_VERTICES_DEF,
  localparam int unsigned IDX_W = $clog2(NUM_VERTICES),
  localparam int unsigned CNT_W = $clog2(NUM_VERTICES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_clr_i,
  input  logic [CNT_W-1:0] n_i,
  input  logic             q_valid_i,
  input  item_t            q_item_i,
  output logic             q_pop_o,
  output logic             res_valid_o,
  output result_t          res_o,
  input  logic             out_stall_i
);

  localparam int unsigned VTX_W = 3 * CRD_W;

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_FILL     = 17'h00002,
    S_GR0      = 17'h00004,
    S_GR1      = 17'h00008,
    S_UPD_RD   = 17'h00010,
    S_UPD_SQ   = 17'h00020,
    S_UPD_ROOT = 17'h00040,
    S_UPD_DIV  = 17'h00080,
    S_SUM_RD   = 17'h00100,
    S_SUM_WR   = 17'h00200,
    S_SMP_M0   = 17'h00400,
    S_SMP_M1   = 17'h00800,
    S_SMP_M2   = 17'h01000,
    S_SRCH_A   = 17'h02000,
    S_SRCH_B   = 17'h04000,
    S_SMP_VRD  = 17'h08000,
    S_SMP_OUT  = 17'h10000
  } state_e;

  state_e              state_q, state_d;
  item_t               item_q, item_d;
  logic                ready_q, ready_d;
  logic [CNT_W-1:0]    k_q, k_d;
  logic [1:0]          j_q, j_d;
  logic [IDX_W-1:0]    lo_q, lo_d, hi_q, hi_d, mid;
  logic [IDX_W:0]      mid_sum;
  logic [TOT_W-1:0]    tot_q, tot_d, acc_q, acc_d, tgt_q, tgt_d, acc_new;
  logic [2*CRD_W-1:0]  gr_q, gr_d;
  logic [RAD_W-1:0]    sum_q, sum_d;
  logic                sq_start_q;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [2*MUL_W-1:0]  mul_p_q;
  result_t             res_q, res_d;
  logic                res_valid_q, res_valid_d;

  logic [VTX_W-1:0]    vmem [NUM_VERTICES];
  logic [VTX_W-1:0]    v_rd_q, v_wdata;
  logic [IDX_W-1:0]    v_raddr, v_waddr;
  logic                v_we;
  logic [WGT_W-1:0]    wmem [NUM_VERTICES];
  logic [WGT_W-1:0]    w_rd_q, w_wdata;
  logic                w_we;
  logic [TOT_W-1:0]    cmem [NUM_VERTICES];
  logic [TOT_W-1:0]    c_rd_q, c_wdata;
  logic                c_we;

  logic                sq_done, div_start, div_done;
  logic [ROOT_W-1:0]   root;
  logic [CRD_W-1:0]    quot;
  logic [DVS_W-1:0]    divisor;
  logic [MUL_W-1:0]    dx, dy, dz;
  logic [WGT_W:0]      w_sum;
  logic [WGT_W-1:0]    w_new;
  logic [TOT_W-1:0]    fill_total;

  function automatic logic [MUL_W-1:0] abs_diff(logic [CRD_W-1:0] a, logic [CRD_W-1:0] b);
    logic signed [CRD_W:0] d;
    d = $signed({a[CRD_W-1], a}) - $signed({b[CRD_W-1], b});
    return d[CRD_W] ? MUL_W'(-d) : MUL_W'(d);
  endfunction

  function automatic result_t plain_res(status_e st, logic [TOT_W-1:0] t);
    result_t r;
    r        = '0;
    r.status = st;
    r.total  = t;
    return r;
  endfunction

  assign dx = abs_diff(item_q.x, v_rd_q[VTX_W-1 -: CRD_W]);
  assign dy = abs_diff(item_q.y, v_rd_q[2*CRD_W-1 -: CRD_W]);
  assign dz = abs_diff(item_q.z, v_rd_q[CRD_W-1:0]);

  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = mid_sum[IDX_W:1];
  assign divisor    = {1'b0, root} + DVS_W'(item_q.radius);
  assign acc_new    = acc_q + TOT_W'(w_rd_q);
  assign fill_total = TOT_W'(n_i) << 16;
  assign v_raddr    = (state_q == S_SMP_VRD) ? lo_q : k_q[IDX_W-1:0];
  assign v_waddr    = IDX_W'(q_item_i.slot);
  assign v_wdata    = {q_item_i.x, q_item_i.y, q_item_i.z};

  always_comb begin
    w_sum = {1'b0, w_rd_q} + {1'b0, quot};
    if (item_q.gain_neg) begin
      w_new = (w_rd_q < quot) ? '0 : (w_rd_q - quot);
    end else begin
      w_new = w_sum[WGT_W] ? '1 : w_sum[WGT_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    ready_d     = ready_q;
    k_d         = k_q;
    j_d         = j_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    tot_d       = tot_q;
    acc_d       = acc_q;
    tgt_d       = tgt_q;
    gr_d        = gr_q;
    sum_d       = sum_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    q_pop_o     = 1'b0;
    v_we        = 1'b0;
    w_we        = 1'b0;
    w_wdata     = ONE_Q16;
    c_we        = 1'b0;
    c_wdata     = '0;
    div_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;

    if (res_valid_q && !out_stall_i) begin
      res_valid_d = 1'b0;
    end
    if (cfg_clr_i) begin
      ready_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && !res_valid_q) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          case (q_item_i.cmd)
            CMD_LOAD: begin
              v_we        = q_item_i.slot_ok;
              ready_d     = 1'b0;
              res_d       = plain_res(ST_OK, tot_q);
              res_valid_d = 1'b1;
            end
            CMD_RESET: begin
              k_d     = '0;
              state_d = S_FILL;
            end
            CMD_UPDATE: begin
              if (!ready_q) begin
                res_d       = plain_res(ST_NOT_READY, tot_q);
                res_valid_d = 1'b1;
              end else if (q_item_i.radius_zero) begin
                res_d       = plain_res(ST_ZERO_RADIUS, tot_q);
                res_valid_d = 1'b1;
              end else begin
                state_d = S_GR0;
              end
            end
            default: begin
              if (!ready_q) begin
                res_d       = plain_res(ST_NOT_READY, tot_q);
                res_valid_d = 1'b1;
              end else begin
                state_d = S_SMP_M0;
              end
            end
          endcase
        end
      end
      S_FILL: begin
        w_we    = 1'b1;
        c_we    = 1'b1;
        c_wdata = (TOT_W'(k_q) + TOT_W'(1)) << 16;
        if (k_q == CNT_W'(NUM_VERTICES - 1)) begin
          tot_d       = fill_total;
          ready_d     = 1'b1;
          res_d       = plain_res(ST_OK, fill_total);
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          k_d = k_q + CNT_W'(1);
        end
      end
      S_GR0: begin
        mul_a   = {1'b0, item_q.gmag};
        mul_b   = {1'b0, item_q.radius};
        state_d = S_GR1;
      end
      S_GR1: begin
        gr_d    = mul_p_q[2*CRD_W-1:0];
        k_d     = '0;
        state_d = S_UPD_RD;
      end
      S_UPD_RD: begin
        j_d     = 2'd0;
        state_d = S_UPD_SQ;
      end
      S_UPD_SQ: begin
        j_d = j_q + 2'd1;
        case (j_q)
          2'd0: begin
            mul_a = dx;
            mul_b = dx;
          end
          2'd1: begin
            mul_a = dy;
            mul_b = dy;
            sum_d = RAD_W'(mul_p_q);
          end
          2'd2: begin
            mul_a = dz;
            mul_b = dz;
            sum_d = sum_q + RAD_W'(mul_p_q);
          end
          default: begin
            sum_d   = sum_q + RAD_W'(mul_p_q);
            state_d = S_UPD_ROOT;
          end
        endcase
      end
      S_UPD_ROOT: begin
        if (sq_done) begin
          div_start = 1'b1;
          state_d   = S_UPD_DIV;
        end
      end
      S_UPD_DIV: begin
        if (div_done) begin
          w_we    = 1'b1;
          w_wdata = w_new;
          if ((k_q + CNT_W'(1)) == n_i) begin
            k_d     = '0;
            acc_d   = '0;
            state_d = S_SUM_RD;
          end else begin
            k_d     = k_q + CNT_W'(1);
            state_d = S_UPD_RD;
          end
        end
      end
      S_SUM_RD: begin
        state_d = S_SUM_WR;
      end
      S_SUM_WR: begin
        c_we    = 1'b1;
        c_wdata = acc_new;
        acc_d   = acc_new;
        if ((k_q + CNT_W'(1)) == n_i) begin
          tot_d       = acc_new;
          res_d       = plain_res(ST_OK, acc_new);
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          k_d     = k_q + CNT_W'(1);
          state_d = S_SUM_RD;
        end
      end
      S_SMP_M0: begin
        mul_a   = {1'b0, item_q.draw};
        mul_b   = MUL_W'(tot_q[CRD_W-1:0]);
        state_d = S_SMP_M1;
      end
      S_SMP_M1: begin
        tgt_d   = TOT_W'(mul_p_q[2*CRD_W-1:CRD_W]);
        mul_a   = {1'b0, item_q.draw};
        mul_b   = MUL_W'(tot_q[TOT_W-1:CRD_W]);
        state_d = S_SMP_M2;
      end
      S_SMP_M2: begin
        tgt_d   = tgt_q + mul_p_q[TOT_W-1:0];
        lo_d    = '0;
        hi_d    = IDX_W'(n_i - CNT_W'(1));
        state_d = S_SRCH_A;
      end
      S_SRCH_A: begin
        state_d = (lo_q == hi_q) ? S_SMP_VRD : S_SRCH_B;
      end
      S_SRCH_B: begin
        if (c_rd_q < tgt_q) begin
          lo_d = mid + IDX_W'(1);
        end else begin
          hi_d = mid;
        end
        state_d = S_SRCH_A;
      end
      S_SMP_VRD: begin
        state_d = S_SMP_OUT;
      end
      S_SMP_OUT: begin
        res_d        = plain_res(ST_OK, tot_q);
        res_d.index  = IDX_OUT_W'(lo_q);
        res_d.x      = v_rd_q[VTX_W-1 -: CRD_W];
        res_d.y      = v_rd_q[2*CRD_W-1 -: CRD_W];
        res_d.z      = v_rd_q[CRD_W-1:0];
        res_valid_d  = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b0;
      tot_q       <= '0;
      res_valid_q <= 1'b0;
      sq_start_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      tot_q       <= tot_d;
      res_valid_q <= res_valid_d;
      sq_start_q  <= (state_q == S_UPD_SQ) && (j_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    k_q     <= k_d;
    j_q     <= j_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    acc_q   <= acc_d;
    tgt_q   <= tgt_d;
    gr_q    <= gr_d;
    sum_q   <= sum_d;
    res_q   <= res_d;
    mul_p_q <= {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    v_rd_q <= vmem[v_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem[k_q[IDX_W-1:0]] <= w_wdata;
    end
    w_rd_q <= wmem[k_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      cmem[k_q[IDX_W-1:0]] <= c_wdata;
    end
    c_rd_q <= cmem[mid];
  end

  wvs_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start_q),
    .rad_i   (sum_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  wvs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (gr_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `WVS_ASSERT(a_res_only_idle, res_valid_q |-> (state_q == S_IDLE), "result held outside idle")
  `WVS_ASSERT(a_root_in_wait, sq_done |-> (state_q == S_UPD_ROOT), "root done outside wait")
  `WVS_ASSERT(a_search_bounds, (state_q == S_SRCH_A) |-> (lo_q <= hi_q), "search bounds crossed")
  `WVS_ASSERT_NEXT(a_fill_ready, (state_q == S_FILL) && (state_d == S_IDLE), ready_q, "fill left not ready")

endmodule
